>>> src/dhf_pkg.sv
package dhf_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [10:0] ExpAllOnes = 11'h7ff;
  localparam logic [10:0] ExpBias    = 11'd1023;
  localparam logic [9:0]  DenormMag  = 10'd1022;

  localparam int unsigned MantW = 52;
  localparam int unsigned MagW  = 10;

  // ascii codes
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChOne   = 7'h31;
  localparam logic [6:0] ChDot   = 7'h2e;
  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChPlus  = 7'h2b;
  localparam logic [6:0] ChX     = 7'h78;
  localparam logic [6:0] ChP     = 7'h70;
  localparam logic [6:0] ChI     = 7'h69;
  localparam logic [6:0] ChN     = 7'h6e;
  localparam logic [6:0] ChF     = 7'h66;
  localparam logic [6:0] ChA     = 7'h61;

  typedef enum logic [1:0] {
    KindZero,
    KindInf,
    KindNan,
    KindFinite
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              neg;
    logic              denorm;
    logic              eneg;
    logic [MagW-1:0]   mag;
    logic [MantW-1:0]  mant;
  } entry_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = ChZero + {3'b000, nib};
    end else begin
      c = ChA + {3'b000, nib - 4'd10};
    end
    return c;
  endfunction

  function automatic logic [6:0] dec_char(input logic [3:0] nib);
    return ChZero + {3'b000, nib};
  endfunction

endpackage

>>> src/dhf_front.sv
module dhf_front (
  input  logic            in_valid_i,
  input  logic [63:0]     value_bits_i,
  input  logic            queue_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output dhf_pkg::entry_t entry_o
);
  import dhf_pkg::*;

  logic [10:0]     bexp;
  logic [MantW-1:0] mant;
  logic [10:0]     diff;

  assign bexp = value_bits_i[62:52];
  assign mant = value_bits_i[51:0];

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    entry_o.neg    = value_bits_i[63];
    entry_o.mant   = mant;
    entry_o.denorm = (bexp == '0);
    diff           = '0;

    if (bexp == '0 && mant == '0) begin
      entry_o.kind = KindZero;
    end else if (bexp == ExpAllOnes) begin
      entry_o.kind = (mant == '0) ? KindInf : KindNan;
    end else begin
      entry_o.kind = KindFinite;
    end

    // unbiased exponent as sign and magnitude
    if (bexp == '0) begin
      entry_o.eneg = 1'b1;
      entry_o.mag  = DenormMag;
    end else if (bexp >= ExpBias) begin
      entry_o.eneg = 1'b0;
      diff         = bexp - ExpBias;
      entry_o.mag  = diff[MagW-1:0];
    end else begin
      entry_o.eneg = 1'b1;
      diff         = ExpBias - bexp;
      entry_o.mag  = diff[MagW-1:0];
    end
  end

endmodule

>>> src/dhf_queue.sv
module dhf_queue #(
  parameter int unsigned Depth = dhf_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dhf_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dhf_pkg::entry_t rdata_o
);
  import dhf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q < CntW'(Depth)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");
`endif

endmodule

>>> src/dhf_back.sv
module dhf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  dhf_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [6:0]      char_code_o,
  output logic            last_char_o
);
  import dhf_pkg::*;

  // character positions of the finite form, counted with the leading sign
  localparam logic [4:0] PosSign    = 5'd0;
  localparam logic [4:0] PosZero    = 5'd1;
  localparam logic [4:0] PosX       = 5'd2;
  localparam logic [4:0] PosLead    = 5'd3;
  localparam logic [4:0] PosDot     = 5'd4;
  localparam logic [4:0] PosHexLo   = 5'd5;
  localparam logic [4:0] PosHexHi   = 5'd17;
  localparam logic [4:0] PosP       = 5'd18;
  localparam logic [4:0] PosExpSign = 5'd19;
  localparam logic [4:0] PosDig3    = 5'd20;
  localparam logic [4:0] PosDig2    = 5'd21;
  localparam logic [4:0] PosDig1    = 5'd22;
  localparam logic [4:0] PosDig0    = 5'd23;
  localparam logic [4:0] LastShort  = 5'd2;
  localparam logic [4:0] LastInf    = 5'd3;
  localparam logic [3:0] DabSteps   = 4'd10;

  logic              busy_q, busy_d;
  logic [4:0]        pos_q, pos_d;
  kind_e             kind_q, kind_d;
  logic              denorm_q, denorm_d;
  logic              eneg_q, eneg_d;
  logic [MantW-1:0]  mant_q, mant_d;
  logic [MagW-1:0]   bin_q, bin_d;
  logic [15:0]       bcd_q, bcd_d;
  logic [3:0]        dab_cnt_q, dab_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [6:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              out_ok, adv, is_last, pop;
  logic [4:0]        last_pos;
  logic [6:0]        ch;
  logic [15:0]       bcd_adj;

  assign out_ok  = !out_valid_q || !out_stall_i;
  assign adv     = busy_q && out_ok;

  always_comb begin
    case (kind_q)
      KindZero:   last_pos = LastShort;
      KindNan:    last_pos = LastShort;
      KindInf:    last_pos = LastInf;
      KindFinite: last_pos = PosDig0;
      default:    last_pos = PosDig0;
    endcase
  end

  assign is_last = (pos_q == last_pos);
  assign pop     = q_valid_i && (!busy_q || (adv && is_last));
  assign q_pop_o = pop;

  // character at the current position
  always_comb begin
    ch = ChZero;
    case (kind_q)
      KindZero: begin
        ch = (pos_q == 5'd1) ? ChDot : ChZero;
      end
      KindNan: begin
        ch = (pos_q == 5'd1) ? ChA : ChN;
      end
      KindInf: begin
        case (pos_q)
          5'd0:    ch = ChMinus;
          5'd1:    ch = ChI;
          5'd2:    ch = ChN;
          default: ch = ChF;
        endcase
      end
      KindFinite: begin
        if (pos_q inside {[PosHexLo:PosHexHi]}) begin
          ch = hex_char(mant_q[MantW-1 -: 4]);
        end else begin
          case (pos_q)
            PosSign:    ch = ChMinus;
            PosZero:    ch = ChZero;
            PosX:       ch = ChX;
            PosLead:    ch = denorm_q ? ChZero : ChOne;
            PosDot:     ch = ChDot;
            PosP:       ch = ChP;
            PosExpSign: ch = eneg_q ? ChMinus : ChPlus;
            PosDig3:    ch = dec_char(bcd_q[15:12]);
            PosDig2:    ch = dec_char(bcd_q[11:8]);
            PosDig1:    ch = dec_char(bcd_q[7:4]);
            PosDig0:    ch = dec_char(bcd_q[3:0]);
            default:    ch = ChZero;
          endcase
        end
      end
      default: ch = ChZero;
    endcase
  end

  // one shift-and-add-3 step of the binary to bcd conversion
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      bcd_adj[n*4 +: 4] = (bcd_q[n*4 +: 4] >= 4'd5) ? bcd_q[n*4 +: 4] + 4'd3
                                                    : bcd_q[n*4 +: 4];
    end
  end

  always_comb begin
    busy_d      = busy_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    denorm_d    = denorm_q;
    eneg_d      = eneg_q;
    mant_d      = mant_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    dab_cnt_d   = dab_cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (adv) begin
      out_valid_d = 1'b1;
      out_char_d  = ch;
      out_last_d  = is_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (dab_cnt_q != '0) begin
      bin_d     = {bin_q[MagW-2:0], 1'b0};
      bcd_d     = {bcd_adj[14:0], bin_q[MagW-1]};
      dab_cnt_d = dab_cnt_q - 1'b1;
    end

    if (pop) begin
      busy_d    = 1'b1;
      kind_d    = q_entry_i.kind;
      denorm_d  = q_entry_i.denorm;
      eneg_d    = q_entry_i.eneg;
      mant_d    = q_entry_i.mant;
      bin_d     = q_entry_i.mag;
      bcd_d     = '0;
      dab_cnt_d = DabSteps;
      // positive finite and infinite values skip the sign position
      pos_d     = ((q_entry_i.kind == KindFinite || q_entry_i.kind == KindInf)
                   && !q_entry_i.neg) ? 5'd1 : 5'd0;
    end else if (adv && is_last) begin
      busy_d = 1'b0;
    end else if (adv) begin
      pos_d = pos_q + 1'b1;
      if (kind_q == KindFinite && (pos_q inside {[PosHexLo:PosHexHi]})) begin
        mant_d = {mant_q[MantW-5:0], 4'h0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      kind_q      <= KindZero;
      dab_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pos_q       <= pos_d;
      kind_q      <= kind_d;
      dab_cnt_q   <= dab_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    denorm_q   <= denorm_d;
    eneg_q     <= eneg_d;
    mant_q     <= mant_d;
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = out_char_q;
  assign last_char_o = out_last_q;

`ifndef SYNTHESIS
  a_digits_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && kind_q == KindFinite && pos_q >= PosDig3) |-> (dab_cnt_q == '0))
    else $error("exponent digit sent before conversion finished");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= last_pos))
    else $error("character position beyond end of text");
`endif

endmodule

>>> src/double_to_hex_float_text.sv
// Formats the 64-bit pattern of an IEEE-754 double as hexadecimal float text,
// one 7-bit ASCII character per output request, with last_char_o set on the
// final character: "0.0" for either zero, "inf"/"-inf", "nan", otherwise
// [-]0x1.hhhhhhhhhhhhhp[+-]dddd (leading 0 and exponent -1022 for denormals).
// The output runs at one character per cycle while out_stall_i is low, with no
// gap between values when the next one is queued; zero and nan have 3
// characters, infinity 3 or 4, and a finite number 23 or 24. The single output
// register and the character sequencer behind it set the output pace; the input
// side runs ahead by up to QueueDepth classified values and then stalls.
module double_to_hex_float_text #(
  parameter int unsigned QueueDepth = dhf_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_code_o,
  output logic        last_char_o
);
  import dhf_pkg::*;

  // classified request between front and back
  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_valid;

  // front: split the pattern into class, sign, mantissa and exponent
  dhf_front u_front (
    .in_valid_i   (in_valid_i),
    .value_bits_i (value_bits_i),
    .queue_full_i (queue_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // short queue so the front keeps taking requests while text is sent
  dhf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .rdata_o (pop_entry)
  );

  // back: character sequencer, bcd conversion of the exponent, output register
  dhf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule
